>>> rtl/core/metu_pkg.sv
package metu_pkg;

  // Field and register widths that do not vary with the value width.
  localparam int unsigned KIND_BITS    = 3;
  localparam int unsigned MODE_BITS    = 2;
  localparam int unsigned REG_BITS     = 31;
  localparam int unsigned DT_BITS      = 16;
  localparam int unsigned CNT_BITS     = 7;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Item kinds.
  localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_JUMP   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_TARGET = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ADD    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_SPEED  = 3'd4;

  // Tick modes.
  localparam logic [MODE_BITS-1:0] MODE_SNAP    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_GRAVITY = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LINEAR  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_PULL    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CROSS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [REG_BITS-1:0] CROSS_RESET   = 31'd65536;
  localparam logic [REG_BITS-1:0] GRAVITY_RESET = 31'd65536000;

  // Status of a serial arithmetic unit; done pulses for one cycle.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/core/metu_if.sv
// Input channel: one command beat.
interface metu_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                               valid;
  logic                               ready;
  logic [metu_pkg::KIND_BITS-1:0]     kind;
  logic signed [VALUE_BITS-1:0]       value;
  logic [metu_pkg::DT_BITS-1:0]       time_step;

  modport source (output valid, kind, value, time_step, input ready);
  modport sink (input valid, kind, value, time_step, output ready);
endinterface

// Output channel: one result beat.
interface metu_out_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] position;
  logic                         moving;

  modport source (output valid, position, moving, input ready);
  modport sink (input valid, position, moving, output ready);
endinterface

>>> rtl/core/metu_mul.sv
// Radix-2 shift-add multiplier, least significant multiplier bit first.
// After N steps the product holds a_i * b_i * 2^(BW-N).
module metu_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [AW-1:0]                  a_i,
  input  logic [BW-1:0]                  b_i,
  input  logic [metu_pkg::CNT_BITS-1:0]  nbits_i,
  output logic [AW+BW-1:0]               prod_o,
  output metu_pkg::unit_stat_t           stat_o
);

  logic [AW-1:0]                 a_q;
  logic [BW-1:0]                 b_q;
  logic [AW+BW-1:0]              p_q;
  logic [metu_pkg::CNT_BITS-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [AW:0]                   sum;

  // Add the multiplicand into the top part when the current bit is set.
  assign sum = {1'b0, p_q[AW+BW-1:BW]} + (b_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

  // Step counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - metu_pkg::CNT_BITS'(1);
        if (cnt_q == metu_pkg::CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and product shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      p_q <= {sum, p_q[BW-1:1]};
      b_q <= b_q >> 1;
    end
  end

  assign prod_o      = p_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> rtl/core/metu_div.sv
// Restoring divider, one quotient bit per cycle, most significant first.
module metu_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DW-1:0]        den_i,
  output logic [NW-1:0]        quot_o,
  output metu_pkg::unit_stat_t stat_o
);

  logic [NW-1:0]                 q_q;
  logic [DW-1:0]                 r_q;
  logic [DW-1:0]                 d_q;
  logic [metu_pkg::CNT_BITS-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [DW:0]                   r_sh;
  logic [DW:0]                   r_sub;
  logic                          ge;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign r_sh  = {r_q, q_q[NW-1]};
  assign ge    = r_sh >= {1'b0, d_q};
  assign r_sub = r_sh - {1'b0, d_q};

  // Step counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= metu_pkg::CNT_BITS'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - metu_pkg::CNT_BITS'(1);
        if (cnt_q == metu_pkg::CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and dividend/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      r_q <= ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
      q_q <= {q_q[NW-2:0], ge};
    end
  end

  assign quot_o      = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> rtl/core/motion_easing_tween_unit.sv
// Channel   Modport  Beat                                   Accepted when
// in_i      sink     kind, value, time_step                 valid && ready
// out_o     source   position, moving                       valid && ready
// cfg       write    cfg_we_i, cfg_idx_i, cfg_data_i        cfg_we_i high
//
// Items are taken one at a time; ready is high whenever the sequencer is idle,
// also while an earlier result still waits in the output register.
// Commands and ticks without a serial pass go from S_EXEC straight to S_EMIT.
// Linear ticks take one multiplier pass, gravity ticks two multiplier passes,
// pull ticks a multiplier pass, a divider pass and a second multiplier pass.
// Reset is asynchronous; a stalled output holds the finished item in the sequencer.
module motion_easing_tween_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [metu_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [metu_pkg::REG_BITS-1:0]      cfg_data_i,
  metu_in_if.sink                            in_i,
  metu_out_if.source                         out_o
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned DB = metu_pkg::DT_BITS;
  localparam int unsigned AW = (W + 1 > metu_pkg::REG_BITS) ? W + 1 : metu_pkg::REG_BITS;
  localparam int unsigned BW = W + DB;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned SW = AW + 2;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [BW-1:0] FM_ONE = {{(BW-DB-1){1'b0}}, 1'b1, {DB{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_MUL3,
    S_EMIT
  } state_e;

  // Clamp a wide signed sum to the value range.
  function automatic logic signed [W-1:0] sat_val(input logic signed [SW-1:0] x);
    logic [SW-W:0] top;
    top = x[SW-1:W-1];
    if (&top || ~|top) begin
      sat_val = x[W-1:0];
    end else if (x[SW-1]) begin
      sat_val = VMIN;
    end else begin
      sat_val = VMAX;
    end
  endfunction

  // Sign-extend a value to the sum width.
  function automatic logic signed [SW-1:0] sext(input logic signed [W-1:0] x);
    sext = {{(SW-W){x[W-1]}}, x};
  endfunction

  state_e                         state_q;
  logic [metu_pkg::MODE_BITS-1:0] mode_q;
  logic [metu_pkg::REG_BITS-1:0]  cross_q;
  logic [metu_pkg::REG_BITS-1:0]  grav_q;
  logic [metu_pkg::KIND_BITS-1:0] kind_q;
  logic signed [W-1:0]            val_q;
  logic [DB-1:0]                  dt_q;
  logic signed [W-1:0]            pos_q;
  logic signed [W-1:0]            tgt_q;
  logic signed [W-1:0]            spd_q;
  logic                           act_q;
  logic                           fneg_q;
  logic                           out_valid_q;
  logic signed [W-1:0]            out_pos_q;
  logic                           out_mov_q;

  logic                           mul_start;
  logic [AW-1:0]                  mul_a;
  logic [BW-1:0]                  mul_b;
  logic [metu_pkg::CNT_BITS-1:0]  mul_n;
  logic [PW-1:0]                  prod;
  metu_pkg::unit_stat_t           mul_stat;
  logic                           div_start;
  logic [metu_pkg::REG_BITS-1:0]  div_den;
  logic [BW-1:0]                  quot;
  metu_pkg::unit_stat_t           div_stat;

  logic [W-1:0]                   spd_mag;
  logic [W:0]                     gap_diff;
  logic [W-1:0]                   gap_mag;
  logic                           tgt_gt;
  logic signed [SW-1:0]           pos_ext;
  logic [W-1:0]                   sd;
  logic signed [W-1:0]            pos_grav;
  logic signed [W-1:0]            spd_grav;
  logic [W-1:0]                   mv_lin;
  logic signed [W-1:0]            pos_lin;
  logic [BW-1:0]                  fm_cl;
  logic [AW-1:0]                  mov_hi;
  logic [W:0]                     mov;
  logic                           mov_ovf;
  logic                           mov_neg;
  logic signed [W-1:0]            pos_pull;

  // Magnitudes and direction toward the target.
  assign spd_mag  = spd_q[W-1] ? (~spd_q + W'(1)) : spd_q;
  assign gap_diff = {tgt_q[W-1], tgt_q} - {pos_q[W-1], pos_q};
  assign gap_mag  = gap_diff[W] ? (~gap_diff[W-1:0] + W'(1)) : gap_diff[W-1:0];
  assign tgt_gt   = !gap_diff[W] && (|gap_diff);
  assign pos_ext  = sext(pos_q);

  // Gravity: position moves by velocity*dt, velocity grows by accel*dt.
  assign sd       = prod[BW +: W];
  assign pos_grav = sat_val(spd_q[W-1] ? pos_ext - {{(SW-W){1'b0}}, sd}
                                       : pos_ext + {{(SW-W){1'b0}}, sd});
  assign spd_grav = sat_val(sext(spd_q) + {2'b00, prod[BW +: AW]});

  // Linear: step limited to the remaining gap.
  assign mv_lin  = (sd > gap_mag) ? gap_mag : sd;
  assign pos_lin = sat_val(tgt_gt ? pos_ext + {{(SW-W){1'b0}}, mv_lin}
                                  : pos_ext - {{(SW-W){1'b0}}, mv_lin});

  // Pull: fraction clamped at one unless negative, move rounded up.
  assign div_den  = (cross_q == '0) ? metu_pkg::REG_BITS'(1) : cross_q;
  assign fm_cl    = (!fneg_q && quot > FM_ONE) ? FM_ONE : quot;
  assign mov_hi   = prod[PW-1:DB+W];
  assign mov      = {1'b0, prod[DB +: W]} + (W+1)'(|prod[DB-1:0]);
  assign mov_ovf  = (|mov_hi) || mov[W];
  assign mov_neg  = (!tgt_gt) ^ fneg_q;
  assign pos_pull = mov_ovf ? (mov_neg ? VMIN : VMAX)
                  : sat_val(mov_neg ? pos_ext - {{(SW-W){1'b0}}, mov[W-1:0]}
                                    : pos_ext + {{(SW-W){1'b0}}, mov[W-1:0]});

  // Start requests and operands for the serial units.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_n     = '0;
    div_start = 1'b0;
    case (state_q)
      S_EXEC: begin
        if (kind_q == metu_pkg::KIND_TICK && act_q && mode_q != metu_pkg::MODE_SNAP) begin
          mul_start = 1'b1;
          mul_a     = AW'(spd_mag);
          mul_b     = BW'(dt_q);
          mul_n     = metu_pkg::CNT_BITS'(DB);
        end
      end
      S_MUL1: begin
        if (mul_stat.done && mode_q == metu_pkg::MODE_GRAVITY) begin
          mul_start = 1'b1;
          mul_a     = AW'(grav_q);
          mul_b     = BW'(dt_q);
          mul_n     = metu_pkg::CNT_BITS'(DB);
        end else if (mul_stat.done && mode_q == metu_pkg::MODE_PULL) begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mul_start = 1'b1;
          mul_a     = AW'(gap_mag);
          mul_b     = fm_cl;
          mul_n     = metu_pkg::CNT_BITS'(BW);
        end
      end
      default: ;
    endcase
  end

  metu_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .nbits_i (mul_n),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  metu_div #(
    .NW (BW),
    .DW (metu_pkg::REG_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[BW-DB +: BW]),
    .den_i   (div_den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= metu_pkg::MODE_SNAP;
      cross_q <= metu_pkg::CROSS_RESET;
      grav_q  <= metu_pkg::GRAVITY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        metu_pkg::CFG_MODE:    mode_q  <= cfg_data_i[metu_pkg::MODE_BITS-1:0];
        metu_pkg::CFG_CROSS:   cross_q <= cfg_data_i;
        metu_pkg::CFG_GRAVITY: grav_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, motion state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= '0;
      val_q       <= '0;
      dt_q        <= '0;
      pos_q       <= '0;
      tgt_q       <= '0;
      spd_q       <= '0;
      act_q       <= 1'b0;
      fneg_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_mov_q   <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one is loaded now.
      if (out_valid_q && out_o.ready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            kind_q  <= in_i.kind;
            val_q   <= in_i.value;
            dt_q    <= in_i.time_step;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_EMIT;
          case (kind_q)
            metu_pkg::KIND_TICK: begin
              if (mode_q == metu_pkg::MODE_SNAP) begin
                pos_q <= tgt_q;
              end else if (act_q) begin
                state_q <= S_MUL1;
              end else if (mode_q == metu_pkg::MODE_GRAVITY) begin
                // At rest at or above the target snaps; otherwise arm.
                if (spd_q != '0 || tgt_q != pos_q) begin
                  if (spd_q == '0 && !tgt_gt) begin
                    pos_q <= tgt_q;
                  end else begin
                    act_q <= 1'b1;
                  end
                end
              end else if (tgt_q != pos_q) begin
                act_q <= 1'b1;
              end
            end
            metu_pkg::KIND_JUMP: begin
              pos_q <= val_q;
              tgt_q <= val_q;
            end
            metu_pkg::KIND_TARGET: tgt_q <= val_q;
            metu_pkg::KIND_ADD:    tgt_q <= sat_val(sext(tgt_q) + sext(val_q));
            metu_pkg::KIND_SPEED:  spd_q <= val_q;
            default: ;
          endcase
        end
        S_MUL1: begin
          if (mul_stat.done) begin
            case (mode_q)
              metu_pkg::MODE_GRAVITY: begin
                pos_q   <= pos_grav;
                state_q <= S_MUL2;
              end
              metu_pkg::MODE_LINEAR: begin
                pos_q   <= pos_lin;
                act_q   <= pos_lin != tgt_q;
                state_q <= S_EMIT;
              end
              metu_pkg::MODE_PULL: begin
                fneg_q  <= spd_q[W-1] && (dt_q != '0);
                state_q <= S_DIV;
              end
              default: state_q <= S_EMIT;
            endcase
          end
        end
        S_MUL2: begin
          // Land once the position has reached the target.
          if (mul_stat.done) begin
            if (!tgt_gt) begin
              pos_q <= tgt_q;
              spd_q <= '0;
              act_q <= 1'b0;
            end else begin
              spd_q <= spd_grav;
            end
            state_q <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_stat.done) begin
            pos_q   <= pos_pull;
            act_q   <= pos_pull != tgt_q;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_pos_q   <= pos_q;
            out_mov_q   <= act_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.position = out_pos_q;
  assign out_o.moving   = out_mov_q;

`ifndef SYNTH
  // The multiplier and the divider never run at the same time.
  ap_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // An accepted beat is executed in the next cycle.
  ap_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted beat not executed");

  // While waiting on a multiplier pass, the multiplier is running or finishing.
  ap_mul_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3)
      |-> (mul_stat.busy || mul_stat.done))
    else $error("sequencer waits on an idle multiplier");

  // While waiting on the divider, the divider is running or finishing.
  ap_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // A free output register takes the result and frees the sequencer.
  ap_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || out_o.ready))
      |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded into the output register");
`endif

endmodule

>>> dv/motion_easing_tween_unit_tb.sv
`timescale 1ns / 100ps

module motion_easing_tween_unit_tb;

  localparam int VW = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BEATS = 130;
  localparam int NUM_PHASES = 8;

  localparam logic signed [VW-1:0] VAL_TOP    = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_BOTTOM = {1'b1, {(VW-1){1'b0}}};

  // Kind codes that the block ignores.
  localparam logic [metu_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [metu_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;
  localparam longint unsigned DT_ONE = 64'd65536;
  localparam longint unsigned MOVE_CAP = 64'd1 << (VW + 1);
  localparam longint unsigned U64_TOP = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [VW-1:0] position;
    logic                 moving;
  } tween_result_t;

  // Tween state tracker with a queue of positions still owed by the block.
  class tween_scoreboard;
    logic [metu_pkg::MODE_BITS-1:0] mode;
    logic [metu_pkg::REG_BITS-1:0]  cross_dist;
    logic [metu_pkg::REG_BITS-1:0]  accel;
    longint                         pos;
    longint                         tgt;
    longint                         vel;
    bit                             active;
    tween_result_t                  owed_positions[$];
    int unsigned                    mismatches;

    function new();
      mode = metu_pkg::MODE_SNAP;
      cross_dist = metu_pkg::CROSS_RESET;
      accel = metu_pkg::GRAVITY_RESET;
      pos = 0;
      tgt = 0;
      vel = 0;
      active = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [metu_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [metu_pkg::REG_BITS-1:0] data);
      case (idx)
        metu_pkg::CFG_MODE:    mode = data[metu_pkg::MODE_BITS-1:0];
        metu_pkg::CFG_CROSS:   cross_dist = data;
        metu_pkg::CFG_GRAVITY: accel = data;
        default: ;
      endcase
    endfunction

    function longint clamp_q16(longint x);
      if (x > Q_MAX) return Q_MAX;
      if (x < Q_MIN) return Q_MIN;
      return x;
    endfunction

    function longint unsigned magnitude(longint x);
      return (x < 0) ? longint'(-x) : x;
    endfunction

    // Q16.16 times Q0.16 seconds, magnitude truncated toward zero.
    function longint scale_by_dt(longint v, logic [metu_pkg::DT_BITS-1:0] dt);
      longint unsigned m;
      m = (magnitude(v) * {48'd0, dt}) >> metu_pkg::DT_BITS;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint apply_move(longint base, bit down, longint unsigned m);
      if (m > MOVE_CAP) m = MOVE_CAP;
      return clamp_q16(down ? base - longint'(m) : base + longint'(m));
    endfunction

    // One time step of the selected easing mode.
    function void advance_tween(logic [metu_pkg::DT_BITS-1:0] dt);
      longint unsigned step;
      longint unsigned gap;
      longint unsigned fm;
      longint unsigned m;
      longint unsigned crs;
      longint          prod;
      bit              fneg;
      bit              lower;
      case (mode)
        metu_pkg::MODE_SNAP: begin
          pos = tgt;
        end
        metu_pkg::MODE_GRAVITY: begin
          if (active) begin
            pos = clamp_q16(pos + scale_by_dt(vel, dt));
            vel = clamp_q16(vel + scale_by_dt(longint'({33'd0, accel}), dt));
            if (pos >= tgt) begin
              active = 1'b0;
              pos = tgt;
              vel = 0;
            end
          end else if (vel != 0 || tgt != pos) begin
            // At rest on or above the target it simply snaps.
            if (vel == 0 && pos >= tgt) pos = tgt;
            else active = 1'b1;
          end
        end
        metu_pkg::MODE_LINEAR: begin
          if (active) begin
            step = (magnitude(vel) * {48'd0, dt}) >> metu_pkg::DT_BITS;
            gap = magnitude(tgt - pos);
            if (step > gap) step = gap;
            pos = apply_move(pos, !(pos < tgt), step);
            if (pos == tgt) active = 1'b0;
          end else if (tgt != pos) begin
            active = 1'b1;
          end
        end
        default: begin
          if (active) begin
            gap = magnitude(tgt - pos);
            prod = vel * longint'({48'd0, dt});
            crs = (cross_dist == '0) ? 64'd1 : {33'd0, cross_dist};
            fm = magnitude(prod) / crs;
            fneg = (prod < 0);
            if (!fneg && fm > DT_ONE) fm = DT_ONE;
            // A product that would overflow saturates the move instead.
            if (fm != 0 && gap > (U64_TOP - (DT_ONE - 1)) / fm) m = MOVE_CAP;
            else m = (gap * fm + (DT_ONE - 1)) >> metu_pkg::DT_BITS;
            lower = !(tgt > pos);
            pos = apply_move(pos, lower != fneg, m);
            if (pos == tgt) active = 1'b0;
          end else if (tgt != pos) begin
            active = 1'b1;
          end
        end
      endcase
    endfunction

    function void note_input(logic [metu_pkg::KIND_BITS-1:0] kind,
                             logic signed [VW-1:0] value,
                             logic [metu_pkg::DT_BITS-1:0] dt);
      tween_result_t r;
      case (kind)
        metu_pkg::KIND_TICK:   advance_tween(dt);
        metu_pkg::KIND_JUMP: begin
          pos = value;
          tgt = value;
        end
        metu_pkg::KIND_TARGET: tgt = value;
        metu_pkg::KIND_ADD:    tgt = clamp_q16(tgt + longint'(value));
        metu_pkg::KIND_SPEED:  vel = value;
        default: ;
      endcase
      r.position = pos[VW-1:0];
      r.moving = active;
      owed_positions.push_back(r);
    endfunction

    function void check_result(logic signed [VW-1:0] position, logic moving);
      tween_result_t want;
      if (owed_positions.size() == 0) begin
        $error("result beat with nothing owed: position %0d, moving %0b", position, moving);
        mismatches++;
        return;
      end
      want = owed_positions.pop_front();
      if (position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, position);
        mismatches++;
      end
      if (moving !== want.moving) begin
        $error("moving: expected %0b, actual %0b", want.moving, moving);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_positions.size();
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [metu_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = metu_pkg::CFG_MODE;
  logic [metu_pkg::REG_BITS-1:0]     cfg_data_i = '0;

  metu_in_if #(.VALUE_BITS(VW)) in_ch ();
  metu_out_if #(.VALUE_BITS(VW)) out_ch ();

  motion_easing_tween_unit #(.VALUE_BITS(VW)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  tween_scoreboard sb;
  bit              src_idle_en = 1'b1;
  bit              snk_idle_en = 1'b1;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     beats_sent = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = metu_pkg::KIND_TICK;
    in_ch.value = '0;
    in_ch.time_step = '0;
    out_ch.ready = 1'b1;
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Beat monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.kind, in_ch.value, in_ch.time_step);
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.position, out_ch.moving);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one command beat, with an occasional gap before it.
  task automatic send_beat(input logic [metu_pkg::KIND_BITS-1:0] kind,
                           input logic signed [VW-1:0] value,
                           input logic [metu_pkg::DT_BITS-1:0] dt);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.value <= value;
    in_ch.time_step <= dt;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Hold the sender until every owed result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    // Let the monitor note a beat taken at the current edge first.
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all three registers back to back while the block is idle.
  task automatic apply_config(input logic [metu_pkg::MODE_BITS-1:0] m,
                              input logic [metu_pkg::REG_BITS-1:0] c,
                              input logic [metu_pkg::REG_BITS-1:0] g);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= metu_pkg::CFG_MODE;
    cfg_data_i <= {{(metu_pkg::REG_BITS-metu_pkg::MODE_BITS){1'b0}}, m};
    @(posedge clk_i);
    cfg_idx_i <= metu_pkg::CFG_CROSS;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_idx_i <= metu_pkg::CFG_GRAVITY;
    cfg_data_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(metu_pkg::CFG_MODE, {{(metu_pkg::REG_BITS-metu_pkg::MODE_BITS){1'b0}}, m});
    sb.write_reg(metu_pkg::CFG_CROSS, c);
    sb.write_reg(metu_pkg::CFG_GRAVITY, g);
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    int r;
    case ($urandom_range(0, 5))
      0, 1: r = $urandom();
      2: r = int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: r = VAL_TOP;
          1: r = VAL_BOTTOM;
          2: r = 0;
          3: r = 1;
          default: r = -1;
        endcase
      end
      default: r = int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
    return r;
  endfunction

  function automatic logic [metu_pkg::DT_BITS-1:0] rand_dt();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return 16'd1;
          default: return 16'hFFFF;
        endcase
      end
      1: return 16'($urandom());
      default: return 16'($urandom_range(200, 4000));
    endcase
  endfunction

  // A well-formed motion: place, aim, set the speed, then a run of ticks.
  task automatic run_motion();
    int n;
    send_beat(metu_pkg::KIND_JUMP, rand_value(), 16'($urandom()));
    if ($urandom_range(0, 1) == 0) send_beat(metu_pkg::KIND_TARGET, rand_value(), 16'($urandom()));
    else send_beat(metu_pkg::KIND_ADD, rand_value(), 16'($urandom()));
    send_beat(metu_pkg::KIND_SPEED, rand_value(), 16'($urandom()));
    n = $urandom_range(2, 12);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_beat(metu_pkg::KIND_ADD, rand_value(), rand_dt());
      else send_beat(metu_pkg::KIND_TICK, rand_value(), rand_dt());
    end
  endtask

  // Extremes, every kind and the corner cases of each mode.
  task automatic run_directed();
    // Snap mode with the reset register values.
    send_beat(metu_pkg::KIND_JUMP, VAL_TOP, 16'hFFFF);
    send_beat(metu_pkg::KIND_TARGET, VAL_BOTTOM, 16'h0000);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'hFFFF);
    send_beat(metu_pkg::KIND_ADD, -32'sd1, 16'h0000);
    send_beat(metu_pkg::KIND_ADD, VAL_TOP, 16'h0000);
    send_beat(KIND_SPARE_LO, 32'sh1234_5678, 16'h5A5A);
    send_beat(metu_pkg::KIND_SPEED, VAL_TOP, 16'h0000);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'h0000);

    // Gravity: snap at rest above the target, then a climb toward the top.
    apply_config(metu_pkg::MODE_GRAVITY, metu_pkg::CROSS_RESET, metu_pkg::GRAVITY_RESET);
    send_beat(metu_pkg::KIND_JUMP, 32'sh0002_0000, 16'h0000);
    send_beat(metu_pkg::KIND_TARGET, 32'sd0, 16'h0000);
    send_beat(metu_pkg::KIND_SPEED, 32'sd0, 16'h0000);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'd1092);
    send_beat(metu_pkg::KIND_TARGET, VAL_TOP, 16'h0000);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'd1092);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'hFFFF);

    // Linear ramp across the whole range at the largest speed.
    apply_config(metu_pkg::MODE_LINEAR, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_beat(metu_pkg::KIND_JUMP, VAL_BOTTOM, 16'h0000);
    send_beat(metu_pkg::KIND_TARGET, VAL_TOP, 16'h0000);
    send_beat(metu_pkg::KIND_SPEED, VAL_BOTTOM, 16'h0000);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'hFFFF);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'hFFFF);

    // Pull with a zero cross distance and a negative speed that saturates.
    apply_config(metu_pkg::MODE_PULL, 31'd0, 31'd0);
    send_beat(metu_pkg::KIND_JUMP, 32'sd0, 16'h0000);
    send_beat(metu_pkg::KIND_TARGET, VAL_TOP, 16'h0000);
    send_beat(metu_pkg::KIND_SPEED, VAL_BOTTOM, 16'h0000);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'hFFFF);
    send_beat(metu_pkg::KIND_TICK, 32'sd0, 16'hFFFF);
    send_beat(KIND_SPARE_HI, VAL_BOTTOM, 16'hFFFF);
  endtask

  initial begin
    logic [metu_pkg::MODE_BITS-1:0] m;
    logic [metu_pkg::REG_BITS-1:0]  c;
    logic [metu_pkg::REG_BITS-1:0]  g;
    int unsigned                    phase_end;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          m = metu_pkg::MODE_SNAP;
          c = 31'd1;
          g = 31'd0;
        end
        1: begin
          m = metu_pkg::MODE_GRAVITY;
          c = metu_pkg::CROSS_RESET;
          g = 31'h7FFF_FFFF;
        end
        2: begin
          m = metu_pkg::MODE_LINEAR;
          c = 31'h7FFF_FFFF;
          g = 31'($urandom());
        end
        3: begin
          m = metu_pkg::MODE_PULL;
          c = 31'd1;
          g = metu_pkg::GRAVITY_RESET;
        end
        4: begin
          m = metu_pkg::MODE_PULL;
          c = 31'h7FFF_FFFF;
          g = 31'd0;
        end
        5: begin
          m = metu_pkg::MODE_GRAVITY;
          c = 31'($urandom_range(1, 32'h0010_0000));
          g = 31'($urandom_range(0, 32'h0400_0000));
        end
        6: begin
          m = metu_pkg::MODE_PULL;
          c = 31'(32'd65536 * $urandom_range(1, 256));
          g = 31'($urandom());
        end
        default: begin
          m = metu_pkg::MODE_BITS'($urandom_range(0, 3));
          c = 31'($urandom());
          g = 31'($urandom());
        end
      endcase
      apply_config(m, c, g);
      // The last phase runs at full rate on both sides.
      src_idle_en = (phase != NUM_PHASES - 1);
      snk_idle_en = (phase != NUM_PHASES - 1);
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0)
          send_beat(metu_pkg::KIND_BITS'($urandom()), VW'($urandom()), 16'($urandom()));
        else
          run_motion();
        if (src_idle_en && $urandom_range(0, 63) == 0) drain();
      end
    end

    drain();
    repeat (150) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d result beats never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
